// ===== hw/rtl/ctpd_pkg.sv =====
// Package for the computed-torque PD controller.
// Request, result and saturation structs, command and register codes, sequencer states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ctpd_pkg;

  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] CMD_JOINT = 2'd0;
  localparam logic [1:0] CMD_MASS  = 2'd1;
  localparam logic [1:0] CMD_RUN   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_KP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KD = 2'd1;

  typedef struct packed {
    logic [1:0]         command;
    logic [3:0]         row_index;
    logic [3:0]         col_index;
    logic signed [31:0] mass_value;
    logic signed [31:0] pos_ref;
    logic signed [31:0] pos_meas;
    logic signed [31:0] vel_ref;
    logic signed [31:0] vel_meas;
    logic signed [31:0] bias_torque;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] torque;
    logic [3:0]         joint_out;
    logic               last_joint;
    logic               saturated;
  } out_res_t;

  typedef struct packed {
    logic        clip;
    logic [31:0] val;
  } sat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_KD,
    S_KP,
    S_ACC,
    S_RUN,
    S_DRAIN,
    S_EMIT
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/computed_torque_pd_control.sv =====
// Computed-torque PD controller, top level: gain registers, joint, bias and
// mass stores, one shared 33x33 multiplier and accumulator under a sequencer.
// Depends on ctpd_pkg.
//
//   channel | direction | payload            | handshake
//   in_     | in        | ctpd_pkg::in_req_t  | in_valid / in_ready
//   out_    | out       | ctpd_pkg::out_res_t | out_valid / out_ready
//   cfg_    | in        | cfg_index, cfg_data | cfg_valid / cfg_ready
//
// Mass load: written as the request is accepted. Joint load: kd and kp
// products share the multiplier (S_KD, S_KP), then sum and saturate (S_ACC).
// Compute: per joint, S_RUN issues one multiply-accumulate a cycle through the
// registered memory reads and multiplier, then S_DRAIN and S_EMIT follow.
// A stalled result holds the sequencer at the next joint's emit.
// Synchronous active-low reset clears control state and the gain registers;
// stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module computed_torque_pd_control #(
  parameter int JOINTS = 12
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire ctpd_pkg::in_req_t              in_req,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output ctpd_pkg::out_res_t                  out_res,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [ctpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                    cfg_data
);

  localparam int JW    = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam int AW    = (JOINTS > 1) ? $clog2(JOINTS * JOINTS) : 1;
  localparam int ACC_W = 48 + $clog2(JOINTS) + 2;

  localparam logic [JW-1:0] JLAST = JW'(JOINTS - 1);
  localparam logic [AW-1:0] JA    = AW'(JOINTS);

  localparam logic signed [ACC_W-1:0] SMAX = ACC_W'(64'sh0000_0000_7fff_ffff);
  localparam logic signed [ACC_W-1:0] SMIN = ACC_W'(-64'sh0000_0000_8000_0000);

  function automatic ctpd_pkg::sat_t sat32(input logic signed [ACC_W-1:0] v);
    ctpd_pkg::sat_t s;
    if (v > SMAX) begin
      s.clip = 1'b1;
      s.val  = 32'h7fff_ffff;
    end else if (v < SMIN) begin
      s.clip = 1'b1;
      s.val  = 32'h8000_0000;
    end else begin
      s.clip = 1'b0;
      s.val  = v[31:0];
    end
    return s;
  endfunction

  ctpd_pkg::state_t state_r, state_nxt;

  logic [11:0] kp_r, kd_r;

  logic [JW-1:0] row_r, row_nxt;
  logic [JW-1:0] j_r, j_nxt;
  logic [JW-1:0] jrow_r;
  logic          any_clip_r;
  logic          v1_r, f1_r, l1_r;
  logic          v2_r, f2_r, l2_r;

  logic signed [32:0]      dp_r, dv_r;
  logic signed [32:0]      mul_a, mul_b;
  logic signed [65:0]      prod_r;
  logic signed [65:0]      prod_sh;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] term_run, term_joint, bias_ext, accel_sum;

  logic signed [31:0] mass_mem  [JOINTS*JOINTS];
  logic [32:0]        accel_mem [JOINTS];
  logic signed [31:0] bias_mem  [JOINTS];
  logic signed [31:0] mass_q;
  logic [32:0]        accel_q;
  logic signed [31:0] bias_q;

  logic          in_acc, joint_ok, mass_ok;
  logic          acc_joint, acc_mass, acc_run;
  logic          issue, accel_we, out_load;
  logic [AW-1:0] mass_waddr, mass_raddr;

  ctpd_pkg::sat_t     accel_sat, torque_sat;
  ctpd_pkg::out_res_t out_res_r;
  logic               out_valid_r;

  assign in_acc    = in_valid && in_ready;
  assign joint_ok  = int'(in_req.row_index) < JOINTS;
  assign mass_ok   = joint_ok && (int'(in_req.col_index) < JOINTS);
  assign acc_joint = in_acc && (in_req.command == ctpd_pkg::CMD_JOINT) && joint_ok;
  assign acc_mass  = in_acc && (in_req.command == ctpd_pkg::CMD_MASS) && mass_ok;
  assign acc_run   = in_acc && (in_req.command == ctpd_pkg::CMD_RUN);

  assign mass_waddr = AW'(JW'(in_req.row_index)) * JA + AW'(JW'(in_req.col_index));
  assign mass_raddr = AW'(row_r) * JA + AW'(j_r);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r <= '0;
      kd_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == ctpd_pkg::REG_KP) kp_r <= cfg_data[11:0];
      if (cfg_index == ctpd_pkg::REG_KD) kd_r <= cfg_data[11:0];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ctpd_pkg::S_IDLE: begin
        if (acc_joint) state_nxt = ctpd_pkg::S_KD;
        else if (acc_run) state_nxt = ctpd_pkg::S_RUN;
      end
      ctpd_pkg::S_KD:  state_nxt = ctpd_pkg::S_KP;
      ctpd_pkg::S_KP:  state_nxt = ctpd_pkg::S_ACC;
      ctpd_pkg::S_ACC: state_nxt = ctpd_pkg::S_IDLE;
      ctpd_pkg::S_RUN: begin
        if (j_r == JLAST) state_nxt = ctpd_pkg::S_DRAIN;
      end
      ctpd_pkg::S_DRAIN: begin
        if (v2_r && l2_r) state_nxt = ctpd_pkg::S_EMIT;
      end
      ctpd_pkg::S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = (row_r == JLAST) ? ctpd_pkg::S_IDLE : ctpd_pkg::S_RUN;
        end
      end
      default: state_nxt = ctpd_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    issue    = 1'b0;
    accel_we = 1'b0;
    out_load = 1'b0;
    row_nxt  = row_r;
    j_nxt    = j_r;
    mul_a    = {mass_q[31], mass_q};
    mul_b    = {accel_q[31], accel_q[31:0]};
    unique case (state_r)
      ctpd_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (acc_run) begin
          row_nxt = '0;
          j_nxt   = '0;
        end
      end
      ctpd_pkg::S_KD: begin
        mul_a = dv_r;
        mul_b = $signed({21'b0, kd_r});
      end
      ctpd_pkg::S_KP: begin
        mul_a = dp_r;
        mul_b = $signed({21'b0, kp_r});
      end
      ctpd_pkg::S_ACC: accel_we = 1'b1;
      ctpd_pkg::S_RUN: begin
        issue = 1'b1;
        j_nxt = (j_r == JLAST) ? '0 : j_r + 1'b1;
      end
      ctpd_pkg::S_DRAIN: ;
      ctpd_pkg::S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_load = 1'b1;
          row_nxt  = row_r + 1'b1;
          j_nxt    = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ctpd_pkg::S_IDLE;
      row_r       <= '0;
      j_r         <= '0;
      any_clip_r  <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      j_r         <= j_nxt;
      v1_r        <= issue;
      v2_r        <= v1_r;
      out_valid_r <= out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
      if (acc_run) any_clip_r <= 1'b0;
      else if (v1_r) any_clip_r <= any_clip_r | accel_q[32];
    end
  end

  // datapath
  assign prod_sh    = prod_r >>> 16;
  assign term_run   = ACC_W'(prod_sh);
  assign term_joint = ACC_W'(prod_r);
  assign bias_ext   = ACC_W'(bias_q);
  assign accel_sum  = acc_r + term_joint;
  assign accel_sat  = sat32(accel_sum);
  assign torque_sat = sat32(acc_r);

  always_ff @(posedge clk) begin
    f1_r   <= (j_r == '0);
    l1_r   <= (j_r == JLAST);
    f2_r   <= f1_r;
    l2_r   <= l1_r;
    prod_r <= mul_a * mul_b;
    if (acc_joint) begin
      jrow_r <= JW'(in_req.row_index);
      dp_r   <= {in_req.pos_ref[31], in_req.pos_ref} - {in_req.pos_meas[31], in_req.pos_meas};
      dv_r   <= {in_req.vel_ref[31], in_req.vel_ref} - {in_req.vel_meas[31], in_req.vel_meas};
    end
    if (state_r == ctpd_pkg::S_KP) acc_r <= term_joint;
    else if (v2_r) acc_r <= (f2_r ? bias_ext : acc_r) + term_run;
    if (out_load) begin
      out_res_r.torque     <= torque_sat.val;
      out_res_r.joint_out  <= 4'(row_r);
      out_res_r.last_joint <= (row_r == JLAST);
      out_res_r.saturated  <= torque_sat.clip | any_clip_r;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_mass) mass_mem[mass_waddr] <= in_req.mass_value;
    mass_q <= mass_mem[mass_raddr];
  end

  always_ff @(posedge clk) begin
    if (accel_we) accel_mem[jrow_r] <= {accel_sat.clip, accel_sat.val};
    accel_q <= accel_mem[j_r];
  end

  always_ff @(posedge clk) begin
    if (acc_joint) bias_mem[JW'(in_req.row_index)] <= in_req.bias_torque;
    bias_q <= bias_mem[row_r];
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

`default_nettype wire

// ===== hw/rtl/ctpd_checker.sv =====
// Port-level checks for computed_torque_pd_control, bound to the top level.
// Depends on ctpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ctpd_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire ctpd_pkg::in_req_t              in_req,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire ctpd_pkg::out_res_t             out_res,
  input wire logic                           cfg_valid,
  input wire logic                           cfg_ready,
  input wire logic [ctpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input wire logic [31:0]                    cfg_data
);

  // result held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_res))
    else $error("result changed while stalled");

  // a compute request occupies the block
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_req.command == ctpd_pkg::CMD_RUN) |=> !in_ready)
    else $error("request taken during a compute run");

  // a pending torque that is not the last means the run is still going
  a_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_res.last_joint |-> !in_ready)
    else $error("ready before the run finished");

endmodule

bind computed_torque_pd_control ctpd_checker u_ctpd_checker (.*);

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for computed_torque_pd_control: random and directed
// requests on the in_ channel, gain writes on cfg_, torques checked on out_.
// Depends on ctpd_pkg and the computed_torque_pd_control RTL.
`timescale 1ns / 1ps

module tb;
  import ctpd_pkg::*;

  localparam int JOINTS = 12;
  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE3 = 2'd3;
  localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
  localparam int POS_SPREAD = 1 << 18;
  localparam int MASS_SPREAD = 1 << 17;
  localparam int BIAS_SPREAD = 1 << 22;
  localparam int DRAIN_CYCLES = 16;
  localparam int TIMEOUT_NS = 5_000_000;

  class torque_scoreboard;
    logic [11:0] kp = '0;
    logic [11:0] kd = '0;
    logic signed [31:0] accel [JOINTS];
    bit accel_clip [JOINTS];
    logic signed [31:0] bias [JOINTS];
    logic signed [31:0] mass [JOINTS][JOINTS];
    out_res_t torque_expect[$];
    int mismatches = 0;
    int checked = 0;
    int requests = 0;
    int runs = 0;

    function logic signed [31:0] clamp32(longint v, output bit clipped);
      clipped = 1'b1;
      if (v > longint'(Q_MAX)) return Q_MAX;
      if (v < longint'(Q_MIN)) return Q_MIN;
      clipped = 1'b0;
      return v[31:0];
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      if (idx == REG_KP) kp = data[11:0];
      else if (idx == REG_KD) kd = data[11:0];
    endfunction

    function void note_request(in_req_t r);
      longint dp, dv, sum;
      bit clipped, any_clip;
      out_res_t res;
      requests++;
      case (r.command)
        CMD_JOINT: if (r.row_index < JOINTS) begin
          dp = longint'($signed(r.pos_ref)) - longint'($signed(r.pos_meas));
          dv = longint'($signed(r.vel_ref)) - longint'($signed(r.vel_meas));
          accel[r.row_index] = clamp32(longint'(kd) * dv + longint'(kp) * dp, clipped);
          accel_clip[r.row_index] = clipped;
          bias[r.row_index] = r.bias_torque;
        end
        CMD_MASS: if (r.row_index < JOINTS && r.col_index < JOINTS) begin
          mass[r.row_index][r.col_index] = r.mass_value;
        end
        CMD_RUN: begin
          runs++;
          any_clip = 1'b0;
          foreach (accel_clip[j]) any_clip |= accel_clip[j];
          for (int i = 0; i < JOINTS; i++) begin
            sum = longint'(bias[i]);
            for (int j = 0; j < JOINTS; j++) begin
              // products floored to Q16.16 before the sum
              sum += (longint'(mass[i][j]) * longint'(accel[j])) >>> 16;
            end
            res.torque = clamp32(sum, clipped);
            res.joint_out = 4'(i);
            res.last_joint = (i == JOINTS - 1);
            res.saturated = clipped | any_clip;
            torque_expect.push_back(res);
          end
        end
        default: ;
      endcase
    endfunction

    function void report(string what, out_res_t want, out_res_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%s: expected torque %0d joint %0d last %0b sat %0b, got torque %0d joint %0d last %0b sat %0b",
                 what, want.torque, want.joint_out, want.last_joint, want.saturated,
                 got.torque, got.joint_out, got.last_joint, got.saturated);
      end
    endfunction

    function void check_result(out_res_t got);
      out_res_t want;
      if (torque_expect.size() == 0) begin
        report("unexpected torque", '0, got);
        return;
      end
      want = torque_expect.pop_front();
      checked++;
      if (got.torque !== want.torque || got.joint_out !== want.joint_out ||
          got.last_joint !== want.last_joint || got.saturated !== want.saturated) begin
        report("torque mismatch", want, got);
      end
    endfunction

    function int pending();
      return torque_expect.size();
    endfunction
  endclass

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_req_t in_req = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_res_t out_res;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  torque_scoreboard sb;
  int send_idle = 0;
  int recv_idle = 0;
  int n_settings = 0;

  computed_torque_pd_control #(.JOINTS(JOINTS)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_res);
  end

  function automatic logic [31:0] pick_word(input int spread);
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: return Q_MAX;
          1: return Q_MIN;
          2: return '0;
          default: return '1;
        endcase
      end
      1, 2: return $urandom;
      default: return $urandom_range(2 * spread) - spread;
    endcase
  endfunction

  function automatic in_req_t bare_req(input logic [1:0] cmd);
    in_req_t r;
    r.command = cmd;
    r.row_index = 4'($urandom);
    r.col_index = 4'($urandom);
    r.mass_value = $urandom;
    r.pos_ref = $urandom;
    r.pos_meas = $urandom;
    r.vel_ref = $urandom;
    r.vel_meas = $urandom;
    r.bias_torque = $urandom;
    return r;
  endfunction

  function automatic in_req_t joint_req(input logic [3:0] row, input logic [31:0] pr,
                                        input logic [31:0] pm, input logic [31:0] vr,
                                        input logic [31:0] vm, input logic [31:0] bt);
    in_req_t r;
    r = bare_req(CMD_JOINT);
    r.row_index = row;
    r.pos_ref = pr;
    r.pos_meas = pm;
    r.vel_ref = vr;
    r.vel_meas = vm;
    r.bias_torque = bt;
    return r;
  endfunction

  function automatic in_req_t mass_req(input logic [3:0] row, input logic [3:0] col,
                                       input logic [31:0] val);
    in_req_t r;
    r = bare_req(CMD_MASS);
    r.row_index = row;
    r.col_index = col;
    r.mass_value = val;
    return r;
  endfunction

  function automatic in_req_t random_joint(input logic [3:0] row);
    return joint_req(row, pick_word(POS_SPREAD), pick_word(POS_SPREAD), pick_word(POS_SPREAD),
                     pick_word(POS_SPREAD), pick_word(BIAS_SPREAD));
  endfunction

  function automatic logic [11:0] pick_gain();
    case ($urandom_range(9))
      0: return '0;
      1: return 12'd4095;
      2, 3: return 12'($urandom_range(4095));
      default: return 12'($urandom_range(15, 1));
    endcase
  endfunction

  // mostly well-formed requests; ignored ones come back with useful low
  function automatic void make_item(output in_req_t r, output bit useful);
    int sel;
    sel = $urandom_range(99);
    useful = 1'b1;
    if (sel < 45) begin
      r = random_joint(4'($urandom_range(JOINTS - 1)));
    end else if (sel < 80) begin
      r = mass_req(4'($urandom_range(JOINTS - 1)), 4'($urandom_range(JOINTS - 1)),
                   pick_word(MASS_SPREAD));
    end else if (sel < 88) begin
      r = bare_req(CMD_RUN);
    end else begin
      useful = 1'b0;
      case ($urandom_range(2))
        0: r = bare_req(CMD_NONE);
        1: r = random_joint(4'($urandom_range(15, JOINTS)));
        default: begin
          if ($urandom_range(1)) r = mass_req(4'($urandom_range(15, JOINTS)), 4'($urandom),
                                               pick_word(MASS_SPREAD));
          else r = mass_req(4'($urandom), 4'($urandom_range(15, JOINTS)), pick_word(MASS_SPREAD));
        end
      endcase
    end
  endfunction

  // called and returns at a falling edge; valid is left high for a follow-on request
  task automatic send_req(input in_req_t r);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (!in_ready);
    sb.note_request(r);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.note_config(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_gains(input logic [11:0] p, input logic [11:0] d);
    write_reg(REG_KP, {20'($urandom), p});
    write_reg(REG_KD, {20'($urandom), d});
    if ($urandom_range(1)) write_reg(REG_SPARE2, $urandom);
    else write_reg(REG_SPARE3, $urandom);
    n_settings++;
  endtask

  task automatic fill_stores();
    set_gains(12'($urandom_range(15, 1)), 12'($urandom_range(15, 1)));
    for (int j = 0; j < JOINTS; j++) send_req(random_joint(4'(j)));
    for (int i = 0; i < JOINTS; i++) begin
      for (int j = 0; j < JOINTS; j++) send_req(mass_req(4'(i), 4'(j), pick_word(MASS_SPREAD)));
    end
  endtask

  task automatic directed_checks();
    logic [31:0] bt;
    drain();
    set_gains(12'd4095, 12'd4095);
    // acceleration clipped high on the first joint, low on the last
    send_req(joint_req(4'd0, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX));
    send_req(joint_req(4'(JOINTS - 1), Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN));
    send_req(mass_req(4'd0, 4'd0, Q_MAX));
    send_req(mass_req(4'(JOINTS - 1), 4'd0, Q_MIN));
    send_req(mass_req(4'(JOINTS - 1), 4'(JOINTS - 1), '0));
    send_req(bare_req(CMD_RUN));
    // out-of-range indexes and the unused command must leave the stores alone
    send_req(joint_req(4'd12, Q_MIN, Q_MAX, Q_MAX, Q_MIN, Q_MIN));
    send_req(mass_req(4'd13, 4'd3, Q_MAX));
    send_req(mass_req(4'd2, 4'd15, Q_MIN));
    send_req(bare_req(CMD_NONE));
    // zero gains: extreme errors give zero acceleration, torque equals bias
    drain();
    set_gains('0, '0);
    for (int j = 0; j < JOINTS; j++) begin
      bt = (j == 0) ? Q_MAX : (j == 1) ? Q_MIN : pick_word(BIAS_SPREAD);
      send_req(joint_req(4'(j), Q_MAX, Q_MIN, Q_MIN, Q_MAX, bt));
    end
    send_req(bare_req(CMD_RUN));
  endtask

  task automatic run_random(input int quota);
    in_req_t r;
    bit useful;
    int counted, next_cfg;
    counted = 0;
    next_cfg = 0;
    while (counted < quota) begin
      if (counted >= next_cfg) begin
        drain();
        set_gains(pick_gain(), pick_gain());
        next_cfg += 25;
      end
      make_item(r, useful);
      send_req(r);
      if (useful) counted++;
    end
  endtask

  initial begin
    sb = new();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle = 22;
    recv_idle = 55;
    fill_stores();
    directed_checks();
    run_random(80);
    drain();

    send_idle = 55;
    recv_idle = 22;
    run_random(80);
    drain();

    send_idle = 0;
    recv_idle = 0;
    run_random(75);
    drain();

    $display("Covered %0d requests incl. %0d torque runs, %0d torques checked, %0d gain settings",
             sb.requests, sb.runs, sb.checked, n_settings);
    $display("Mismatches: %0d", sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timed out with %0d torques outstanding", sb.pending());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
